// File: rtl/sha1md_pkg.sv
// Shared types, constants and round functions of the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned NUM_CHAIN  = 5;

  localparam logic [31:0] SHA1_IV [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RND,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      push;    // append one byte to the block
    byte_src_t src;     // where that byte comes from
    logic      load;    // copy the chain words into the working variables
    logic      rnd;     // run one compression round
    logic [6:0] idx;    // round number for rnd
    logic      fold;    // add the working variables into the chain
    logic      rotate;  // move the next digest word to the front
    logic      clear;   // return to the initial message state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] pos;    // byte offset within the current block
  } stat_t;

  function automatic logic [31:0] round_k(input logic [6:0] idx);
    logic [31:0] k;
    if (idx < 7'd20) begin
      k = K_R0;
    end else if (idx < 7'd40) begin
      k = K_R1;
    end else if (idx < 7'd60) begin
      k = K_R2;
    end else begin
      k = K_R3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] idx, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (idx < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (idx < 7'd40) begin
      f = b ^ c ^ d;
    end else if (idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha1md_dp.sv
// Datapath of the SHA-1 block: byte packing, schedule shift line, round unit and chain.
`default_nettype none

module sha1md_dp
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [7:0]  data_byte,
  output      stat_t       stat,
  output      logic [31:0] digest_word
);

  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [31:0] sched_r [NUM_WORDS];
  logic [31:0] sched_nxt [NUM_WORDS];
  logic [31:0] vars_r [NUM_CHAIN];
  logic [31:0] vars_nxt [NUM_CHAIN];
  logic [31:0] chain_r [NUM_CHAIN];
  logic [31:0] chain_nxt [NUM_CHAIN];

  logic [7:0]  push_byte;
  logic [63:0] len_shift;
  logic [31:0] w_exp, w_cur, t_sum, a_v;
  logic        shift_in;
  logic [31:0] shift_word;

  // The length byte for offsets 56..63 is taken most significant first.
  assign len_shift = len_r >> {~pos_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.src)
      SRC_DATA: push_byte = data_byte;
      SRC_MARK: push_byte = PAD_MARKER;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = len_shift[7:0];
      default:  push_byte = 8'h00;
    endcase
  end

  // Shift line: word t is at the head in rounds 0..15; later words are expanded.
  assign w_exp = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_cur = (cmd.idx < 7'd16) ? sched_r[0] : {w_exp[30:0], w_exp[31]};
  assign a_v   = vars_r[0];
  assign t_sum = {a_v[26:0], a_v[31:27]} + round_f(cmd.idx, vars_r[1], vars_r[2], vars_r[3])
               + vars_r[4] + round_k(cmd.idx) + w_cur;

  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    acc_nxt    = acc_r;
    shift_in   = 1'b0;
    shift_word = w_cur;
    if (cmd.push) begin
      pos_nxt = pos_r + 6'd1;
      acc_nxt = {acc_r[15:0], push_byte};
      if (cmd.src == SRC_DATA) begin
        len_nxt = len_r + 64'd8;
      end
      if (pos_r[1:0] == 2'd3) begin
        shift_in   = 1'b1;
        shift_word = {acc_r, push_byte};
      end
    end
    if (cmd.rnd) begin
      shift_in = 1'b1;
    end
    if (cmd.clear) begin
      pos_nxt = 6'd0;
      len_nxt = 64'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      sched_nxt[i] = sched_r[i];
    end
    if (shift_in) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        sched_nxt[i] = sched_r[i + 1];
      end
      sched_nxt[NUM_WORDS - 1] = shift_word;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHAIN; i++) begin
      vars_nxt[i] = vars_r[i];
    end
    if (cmd.load) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        vars_nxt[i] = chain_r[i];
      end
    end else if (cmd.rnd) begin
      vars_nxt[0] = t_sum;
      vars_nxt[1] = vars_r[0];
      vars_nxt[2] = {vars_r[1][1:0], vars_r[1][31:2]};
      vars_nxt[3] = vars_r[2];
      vars_nxt[4] = vars_r[3];
    end
    priority if (cmd.clear) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_nxt[i] = SHA1_IV[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_nxt[i] = chain_r[i] + vars_r[i];
      end
    end else if (cmd.rotate) begin
      for (int i = 0; i < NUM_CHAIN - 1; i++) begin
        chain_nxt[i] = chain_r[i + 1];
      end
      chain_nxt[NUM_CHAIN - 1] = chain_r[0];
    end else begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_nxt[i] = chain_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
      len_r <= 64'd0;
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_r[i] <= SHA1_IV[i];
      end
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    for (int i = 0; i < NUM_WORDS; i++) begin
      sched_r[i] <= sched_nxt[i];
    end
    for (int i = 0; i < NUM_CHAIN; i++) begin
      vars_r[i] <= vars_nxt[i];
    end
  end

  assign stat.pos    = pos_r;
  assign digest_word = chain_r[0];

endmodule

`default_nettype wire

// File: rtl/sha1md_ctrl.sv
// Controller of the SHA-1 block: message intake, padding, round sequencing and digest output.
`default_nettype none

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       byte_present,
  input  wire logic       end_of_message,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] word_index,
  output      logic       last_word,
  input  wire stat_t      stat,
  output      cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       pad_r, pad_nxt;      // closing item seen, padding under way
  logic       mark_r, mark_nxt;    // 0x80 marker already appended
  logic       spill_r, spill_nxt;  // length goes into the following block
  logic       final_r, final_nxt;  // block in flight carries the length
  logic       full;

  assign full = (stat.pos == LAST_POS);

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    widx_nxt  = widx_r;
    pad_nxt   = pad_r;
    mark_nxt  = mark_r;
    spill_nxt = spill_r;
    final_nxt = final_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.src   = SRC_DATA;
    cmd.idx   = round_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push = byte_present;
          if (end_of_message) begin
            pad_nxt  = 1'b1;
            mark_nxt = 1'b0;
          end
          if (byte_present && full) begin
            cmd.load  = 1'b1;
            round_nxt = 7'd0;
            state_nxt = ST_RND;
          end else if (end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (!mark_r) begin
          cmd.src   = SRC_MARK;
          mark_nxt  = 1'b1;
          spill_nxt = (stat.pos >= LEN_POS);
        end else if ((stat.pos >= LEN_POS) && !spill_r) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (full) begin
          cmd.load  = 1'b1;
          round_nxt = 7'd0;
          spill_nxt = 1'b0;
          final_nxt = (cmd.src == SRC_LEN);
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fold  = 1'b1;
        round_nxt = 7'd0;
        widx_nxt  = 3'd0;
        priority if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.rotate = 1'b1;
          widx_nxt   = widx_r + 3'd1;
          if (widx_r == LAST_WORD) begin
            cmd.clear = 1'b1;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            spill_nxt = 1'b0;
            final_nxt = 1'b0;
            widx_nxt  = 3'd0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= 7'd0;
      widx_r  <= 3'd0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      spill_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      widx_r  <= widx_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      spill_r <= spill_nxt;
      final_r <= final_nxt;
    end
  end

  assign word_index = widx_r;
  assign last_word  = (widx_r == LAST_WORD);

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (round_r <= LAST_ROUND))
    else $error("round counter beyond the last round");

  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (widx_r <= LAST_WORD))
    else $error("digest word index out of range");

  a_final_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
    final_r |-> (pad_r && mark_r && !spill_r))
    else $error("length block flagged outside padding");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && final_r) |=> (state_r == ST_OUT && widx_r == 3'd0))
    else $error("digest output did not follow the length block");

endmodule

`default_nettype wire

// File: rtl/sha1_message_digest.sv
// Top level of the SHA-1 message digest block: controller and datapath joined.
//
//  Channel | Ports      | Direction | Contents
//  --------+------------+-----------+-----------------------------------------------
//  input   | in_t*      | slave     | one message byte; byte_present; end of message
//  result  | out_t*     | master    | one digest word with its index; last word flag
//
// A transaction carries one byte, or none when in_tuser is low; one with in_tlast high closes
// the message. Bytes are packed big-endian into a sixteen-word schedule shift line; one round
// unit compresses each full block at one round per cycle. A byte that completes a block starts
// its 80 rounds and then the chain update before the next byte is taken. A closing item pads
// one byte per cycle, spilling the length into a second block when it does not fit, runs the
// last one or two blocks and then offers the five digest words in order. Input is refused
// while a block is compressed, padded or read out; the digest words wait in the chain
// registers while out_tready is low.
// Reset (rst_n low at a clock edge) loads the initial hash values and clears the byte
// position and the length count.
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] byte_present
  input  wire logic        in_tlast,   // end_of_message
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output      logic        out_tlast   // last_word
);

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  // The controller sequences intake, padding, rounds and readout.
  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .byte_present   (in_tuser),
    .end_of_message (in_tlast),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .word_index     (word_index),
    .last_word      (out_tlast),
    .stat           (stat),
    .cmd            (cmd)
  );

  // The datapath holds the block, the working variables, the chain and the length.
  sha1md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, word_index, digest_word};

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the SHA-1 message digest block, with its own digest predictor.
`default_nettype none

module tb_top;

  // One transaction offered on the byte stream. The hold flag makes the driver wait until
  // every digest word owed so far has been collected before it offers this transaction.
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       hold;
  } msg_item_t;

  // One digest word as the result stream should present it.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] KC0 = 32'h5A827999;
  localparam logic [31:0] KC1 = 32'h6ED9EBA1;
  localparam logic [31:0] KC2 = 32'h8F1BBCDC;
  localparam logic [31:0] KC3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         LEN_OFFSET = 56;
  localparam int         IDLE_PCT   = 36;
  localparam int         TAIL_WAIT  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] byte_present
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] digest_word, [34:32] word_index, rest zero
  logic        out_tlast;          // last_word

  sha1_message_digest uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  msg_item_t   item_q[$];
  digest_exp_t digest_q[$];

  int err_count       = 0;
  int items_sent      = 0;   // transactions taken by the block
  int total_items     = 0;
  int planned_items   = 0;   // transactions that carry a byte or close a message
  int predicted_words = 0;   // digest words owed in total
  int got_count       = 0;   // digest words collected; written with nonblocking updates only

  // Predictor state: chaining value, schedule ring, message length and block offset.
  logic [31:0] hash_h [5];
  logic [31:0] sched_w [16];
  logic [63:0] msg_bits;
  int unsigned blk_pos;

  initial begin
    forever #5 clk = ~clk;
  end

  // A hang anywhere shows up here; the slowest correct run needs far fewer cycles.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Digest predictor
  // ---------------------------------------------------------------------------

  task automatic restart_digest();
    hash_h[0] = IV0;
    hash_h[1] = IV1;
    hash_h[2] = IV2;
    hash_h[3] = IV3;
    hash_h[4] = IV4;
    foreach (sched_w[i]) sched_w[i] = '0;
    msg_bits = '0;
    blk_pos  = 0;
  endtask

  // Bytes go in big-endian: offset 0 lands in the top byte of word 0. The first byte of a
  // word clears whatever the previous block left in it.
  task automatic place_byte(input int unsigned pos, input logic [7:0] b);
    int unsigned wi;
    int unsigned lane;
    wi   = (pos >> 2) & 15;
    lane = pos & 3;
    if (lane == 0) begin
      sched_w[wi] = '0;
    end
    sched_w[wi][31 - 8 * lane -: 8] = b;
  endtask

  // Eighty rounds over the schedule ring, which is expanded in place from round 16 on.
  task automatic sha1_compress();
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int s;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16) begin
        x = sched_w[(s + 13) & 15] ^ sched_w[(s + 8) & 15] ^ sched_w[(s + 2) & 15] ^ sched_w[s];
        sched_w[s] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = KC0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = KC1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = KC2;
      end else begin
        f = b ^ c ^ d;
        k = KC3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + sched_w[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endtask

  // Applies one accepted transaction. A closing transaction pads the message, queues the
  // five digest words and starts the next message from the initial hash values.
  task automatic absorb_item(input logic [7:0] data, input logic present, input logic last);
    int unsigned pos;
    digest_exp_t dw;
    if (present) begin
      place_byte(blk_pos, data);
      msg_bits += 64'd8;
      blk_pos = (blk_pos + 1) & 63;
      if (blk_pos == 0) begin
        sha1_compress();
      end
    end
    if (last) begin
      pos = blk_pos;
      place_byte(pos, PAD_BYTE);
      pos++;
      // No room for the length field: zero out this block and spill into another one.
      if (pos > LEN_OFFSET) begin
        while (pos < 64) begin
          place_byte(pos, 8'h00);
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < LEN_OFFSET) begin
        place_byte(pos, 8'h00);
        pos++;
      end
      sched_w[14] = msg_bits[63:32];
      sched_w[15] = msg_bits[31:0];
      sha1_compress();
      for (int i = 0; i < 5; i++) begin
        dw.word = hash_h[i];
        dw.idx  = 3'(i);
        dw.last = (i == 4);
        digest_q.push_back(dw);
      end
      predicted_words += 5;
      restart_digest();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic add_item(input logic [7:0] data, input logic present, input logic last,
                          input logic hold);
    msg_item_t it;
    it.data    = data;
    it.present = present;
    it.last    = last;
    it.hold    = hold;
    item_q.push_back(it);
    if (present || last) begin
      planned_items++;
    end
  endtask

  // A message of len random bytes. It is closed either on its final byte or by a separate
  // empty closing transaction; noisy messages get idle transactions sprinkled between bytes.
  task automatic add_message(input int len, input logic hold, input logic empty_close,
                             input logic noisy);
    logic h;
    h = hold;
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 99) < 8) begin
        add_item(8'($urandom), 1'b0, 1'b0, h);
        h = 1'b0;
      end
      add_item(8'($urandom), 1'b1, !empty_close && (i == len - 1), h);
      h = 1'b0;
    end
    if (len == 0 || empty_close) begin
      add_item(8'($urandom), 1'b0, 1'b1, h);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the queued transactions, holding each until the block takes it
  // ---------------------------------------------------------------------------

  wire send_calm = (items_sent >= 40) && (items_sent < 110);
  wire recv_calm = (got_count >= 20) && (got_count < 45);

  always @(posedge clk) begin
    msg_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_item(in_tdata, in_tuser, in_tlast);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (item_q.size() != 0 && !(item_q[0].hold && got_count != predicted_words) &&
            (send_calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.present;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each digest word transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    digest_exp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_count <= got_count + 1;
        if (digest_q.size() == 0) begin
          flag_error($sformatf("unexpected digest word %h index %0d",
                               out_tdata[31:0], out_tdata[34:32]));
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.word) begin
            flag_error($sformatf("digest word %0d: got %h, want %h",
                                 want.idx, out_tdata[31:0], want.word));
          end
          if (out_tdata[34:32] !== want.idx) begin
            flag_error($sformatf("word index: got %0d, want %0d", out_tdata[34:32], want.idx));
          end
          if (out_tlast !== want.last) begin
            flag_error($sformatf("last flag on word %0d: got %b, want %b",
                                 want.idx, out_tlast, want.last));
          end
        end
      end
      out_tready <= recv_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, release reset, wait for the digests, give the verdict
  // ---------------------------------------------------------------------------

  initial begin
    int r;
    int len;
    int msgs;

    restart_digest();

    // Directed messages. An idle transaction first, which must change nothing.
    add_item(8'hFF, 1'b0, 1'b0, 1'b0);
    // The empty message, closed by a transaction that carries no byte.
    add_item(8'($urandom), 1'b0, 1'b1, 1'b0);
    // The classic three-byte message.
    add_item(8'h61, 1'b1, 1'b0, 1'b0);
    add_item(8'h62, 1'b1, 1'b0, 1'b0);
    add_item(8'h63, 1'b1, 1'b1, 1'b0);
    // A single all-ones byte that closes its own message.
    add_item(8'hFF, 1'b1, 1'b1, 1'b0);
    // A zero byte, then an empty closing transaction whose ignored data is all ones.
    add_item(8'h00, 1'b1, 1'b0, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1, 1'b0);
    // An idle transaction in the middle of a message.
    add_item(8'h5A, 1'b1, 1'b0, 1'b0);
    add_item(8'hA5, 1'b0, 1'b0, 1'b0);
    add_item(8'hC3, 1'b1, 1'b1, 1'b0);

    // The padding spills into a second block when 56 bytes are already in the first, and a
    // whole block of data is compressed before padding starts at 64 bytes.
    add_message(56, 1'b1, 1'b0, 1'b0);
    add_message(64, 1'b0, 1'b1, 1'b1);

    // Random messages: mostly short, some around the block and padding boundaries, a few
    // tiny. Every fourth one waits for the digest words still owed.
    msgs = 0;
    while (planned_items < 210 || msgs < 8) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(0, 12);
      end else if (r < 9) begin
        len = $urandom_range(52, 66);
      end else begin
        len = $urandom_range(0, 2);
      end
      add_message(len, (msgs % 4) == 3, $urandom_range(0, 2) == 0, 1'b1);
      msgs++;
    end
    total_items = item_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge so that every update of the rising edge has settled.
    while (items_sent != total_items || got_count != predicted_words) begin
      @(negedge clk);
    end
    repeat (TAIL_WAIT) @(negedge clk);

    if (digest_q.size() != 0) begin
      flag_error($sformatf("%0d digest words never arrived", digest_q.size()));
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/sha1md_pkg.sv
rtl/sha1md_dp.sv
rtl/sha1md_ctrl.sv
rtl/sha1_message_digest.sv
dv/tb_top.sv
